// ===== src/bat_pkg.sv =====
package bat_pkg;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_EDIT   = 3'd3,
        MODE_READ   = 3'd4,
        MODE_SEARCH = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADIDX   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_mode              mode;
        logic [3:0]         index;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [3:0]         found_position;
        logic [4:0]         element_count;
    } t_res;

    typedef struct packed {
        t_cell_op op;
        logic     tok_load;
    } t_cell_ctl;

endpackage

// ===== src/bounded_array_table.sv =====
// bounded_array_table: dense table of signed 32-bit words held in a row of cells.
// command channel: a transaction is taken at a rising edge with start high and
// busy low; i_cmd carries mode, index and value.
// result channel: o_valid is high for exactly one cycle with o_res; the receiver
// cannot stall, so every result must be taken in the cycle it is shown.
// append, insert, delete, edit, read and unused modes never raise busy: the
// result appears in the cycle after acceptance and busy stays low, so such
// commands can be issued every cycle.
// search sends a token down the cell row, one cell per cycle, comparing the key
// against that cell; busy stays high until a match is found or every stored entry
// has been compared, and the result is shown in the same cycle that busy falls.
// configuration: i_cfg_we writes the capacity register from i_cfg_wdata; the user must
// write it only while no transaction is in flight, the block does not enforce this.
// reset (synchronous, active low): table empty, capacity 16, no search running,
// no result pending.
module bounded_array_table #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bat_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output bat_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 5) ? CW : 5;

    logic [4:0]          r_cap;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic                r_busy;
    logic                n_busy;
    logic [CW-1:0]       r_scan;
    logic [CW-1:0]       n_scan;
    logic signed [31:0]  r_key;
    logic signed [31:0]  n_key;
    logic                r_valid;
    logic                n_valid;
    bat_pkg::t_res       r_res;
    bat_pkg::t_res       n_res;

    logic                accept;
    logic                full;
    logic                hit;
    logic                finish;
    logic                shift_en;
    logic [4:0]          cap_lo;
    logic [WW-1:0]       cnt_w;
    logic [WW-1:0]       idx_w;
    logic signed [31:0]  rd_or;

    logic signed [31:0]  w_data [DEPTH];
    logic [DEPTH-1:0]    w_tok;
    logic [DEPTH-1:0]    w_hit;
    bat_pkg::t_cell_ctl  w_ctl [DEPTH];

    assign accept   = start && !r_busy;
    assign cap_lo   = (r_cap == 5'd0) ? 5'd1 : r_cap;
    assign cnt_w    = WW'(r_cnt);
    assign idx_w    = WW'(i_cmd.index);
    assign full     = (cnt_w >= WW'(cap_lo)) || (cnt_w >= WW'(DEPTH));
    // a match only counts on a cell that holds a stored entry
    assign hit      = (|w_hit) && (WW'(r_scan) < cnt_w);
    assign finish   = r_busy && (hit || (WW'(r_scan) >= cnt_w));
    assign shift_en = r_busy && !finish;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WW-1:0]      pos;
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            logic               tok_in;

            assign pos = WW'(gi);

            if (gi == 0) begin : g_first
                assign left_d = '0;
                assign tok_in = 1'b1;
            end else begin : g_mid
                assign left_d = w_data[gi-1];
                assign tok_in = w_tok[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_inner
                assign right_d = w_data[gi+1];
            end

            always_comb begin
                w_ctl[gi].op       = bat_pkg::CELL_HOLD;
                w_ctl[gi].tok_load = (gi == 0) ? (accept && i_cmd.mode == bat_pkg::MODE_SEARCH)
                                               : shift_en;
                if (accept) begin
                    case (i_cmd.mode)
                        bat_pkg::MODE_APPEND: begin
                            if (!full && pos == cnt_w)
                                w_ctl[gi].op = bat_pkg::CELL_LOAD;
                        end
                        bat_pkg::MODE_INSERT: begin
                            if (!full && idx_w <= cnt_w) begin
                                if (pos == idx_w)
                                    w_ctl[gi].op = bat_pkg::CELL_LOAD;
                                else if (pos > idx_w && pos <= cnt_w)
                                    w_ctl[gi].op = bat_pkg::CELL_LEFT;
                            end
                        end
                        bat_pkg::MODE_DELETE: begin
                            if (idx_w < cnt_w && pos >= idx_w && (pos + WW'(1)) < cnt_w)
                                w_ctl[gi].op = bat_pkg::CELL_RIGHT;
                        end
                        bat_pkg::MODE_EDIT: begin
                            if (idx_w < cnt_w && pos == idx_w)
                                w_ctl[gi].op = bat_pkg::CELL_LOAD;
                        end
                        default: begin
                            w_ctl[gi].op = bat_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end

            bat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[gi]),
                .i_left  (left_d),
                .i_right (right_d),
                .i_load  (i_cmd.value),
                .i_key   (r_key),
                .i_tok   (tok_in),
                .o_data  (w_data[gi]),
                .o_tok   (w_tok[gi]),
                .o_hit   (w_hit[gi])
            );
        end
    endgenerate

    // one-hot select of the addressed cell
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (WW'(i) == idx_w)
                rd_or = rd_or | w_data[i];
        end
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_scan  = r_scan;
        n_key   = r_key;
        n_valid = 1'b0;
        n_res   = r_res;

        if (r_busy) begin
            n_scan = r_scan + CW'(1);
            if (finish) begin
                n_busy                  = 1'b0;
                n_valid                 = 1'b1;
                n_res.status            = hit ? bat_pkg::ST_OK : bat_pkg::ST_NOTFOUND;
                n_res.read_value        = '0;
                n_res.found_position    = hit ? 4'(r_scan) : 4'd0;
                n_res.element_count     = 5'(r_cnt);
            end
        end else if (accept) begin
            n_res.status         = bat_pkg::ST_OK;
            n_res.read_value     = '0;
            n_res.found_position = 4'd0;
            n_valid              = 1'b1;
            case (i_cmd.mode)
                bat_pkg::MODE_APPEND: begin
                    if (full)
                        n_res.status = bat_pkg::ST_FULL;
                    else
                        n_cnt = r_cnt + CW'(1);
                end
                bat_pkg::MODE_INSERT: begin
                    if (full)
                        n_res.status = bat_pkg::ST_FULL;
                    else if (idx_w > cnt_w)
                        n_res.status = bat_pkg::ST_BADIDX;
                    else
                        n_cnt = r_cnt + CW'(1);
                end
                bat_pkg::MODE_DELETE: begin
                    if (idx_w >= cnt_w)
                        n_res.status = bat_pkg::ST_BADIDX;
                    else
                        n_cnt = r_cnt - CW'(1);
                end
                bat_pkg::MODE_EDIT: begin
                    if (idx_w >= cnt_w)
                        n_res.status = bat_pkg::ST_BADIDX;
                end
                bat_pkg::MODE_READ: begin
                    if (idx_w >= cnt_w)
                        n_res.status = bat_pkg::ST_BADIDX;
                    else
                        n_res.read_value = rd_or;
                end
                bat_pkg::MODE_SEARCH: begin
                    n_valid = 1'b0;
                    n_busy  = 1'b1;
                    n_scan  = '0;
                    n_key   = i_cmd.value;
                end
                default: begin
                    n_res.status = bat_pkg::ST_OK;
                end
            endcase
            n_res.element_count = 5'(n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_scan <= n_scan;
        r_key  <= n_key;
        if (!i_rst_n) begin
            r_cap   <= 5'd16;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_cnt) <= WW'(DEPTH))
        else $error("element count above depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one search token in the cell row");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok) |-> r_busy)
        else $error("search token alive while not busy");

    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_busy) && $past(i_rst_n)) |-> r_valid)
        else $error("search ended without a result");

    a_cnt_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_cnt != $past(r_cnt)) |-> r_valid)
        else $error("element count changed without a transaction result");
`endif

endmodule

// ===== src/bat_cell.sv =====
module bat_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bat_pkg::t_cell_ctl  i_ctl,
    input  logic signed [31:0]  i_left,
    input  logic signed [31:0]  i_right,
    input  logic signed [31:0]  i_load,
    input  logic signed [31:0]  i_key,
    input  logic                i_tok,
    output logic signed [31:0]  o_data,
    output logic                o_tok,
    output logic                o_hit
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_tok;
    logic               n_tok;

    always_comb begin
        case (i_ctl.op)
            bat_pkg::CELL_LOAD:  n_data = i_load;
            bat_pkg::CELL_LEFT:  n_data = i_left;
            bat_pkg::CELL_RIGHT: n_data = i_right;
            default:             n_data = r_data;
        endcase
        n_tok = i_ctl.tok_load & i_tok;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_data = r_data;
    assign o_tok  = r_tok;
    assign o_hit  = r_tok && (r_data == i_key);

endmodule
